@@ rtl/planar_tile_sprite_renderer_assert.svh @@
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible in the calling scope.
`ifndef PLANAR_TILE_SPRITE_RENDERER_ASSERT_SVH
`define PLANAR_TILE_SPRITE_RENDERER_ASSERT_SVH

// Check that a condition implies another one in the same cycle.
`define PTSR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptsr check failed");

// Check that a condition implies another one in the next cycle.
`define PTSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptsr check failed");

`endif

@@ rtl/ptsr_pkg.sv @@
`default_nettype none

package ptsr_pkg;

    // Default geometry
    localparam int PATTERN_BYTES_DEF = 4096;
    localparam int FRAME_LINES_DEF   = 224;

    // Field and bus widths
    localparam int PATTERN_ADDR_W = 12;
    localparam int S_TDATA_W      = 72;
    localparam int M_TDATA_W      = 40;
    localparam int COLOR_W        = 24;
    localparam int TILE_ROWS      = 8;

    // Sprite vertical window and the attribute code that forces color zero
    localparam logic [7:0] SPRITE_Y_FIRST    = 8'd8;
    localparam logic [7:0] SPRITE_Y_END      = 8'd232;
    localparam logic [1:0] SPRITE_FORCE_ZERO = 2'b11;

    // Palette reset colors
    localparam logic [COLOR_W-1:0] COLOR_ZERO_RST  = 24'h000001;
    localparam logic [COLOR_W-1:0] COLOR_ONE_RST   = 24'hF8F8F8;
    localparam logic [COLOR_W-1:0] COLOR_TWO_RST   = 24'hF85898;
    localparam logic [COLOR_W-1:0] COLOR_THREE_RST = 24'hE40058;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TILE   = 2'd1,
        CMD_SPRITE = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_COLOR_ZERO  = 2'd0,
        REG_COLOR_ONE   = 2'd1,
        REG_COLOR_TWO   = 2'd2,
        REG_COLOR_THREE = 2'd3
    } reg_index_t;

    typedef logic [3:0][COLOR_W-1:0] palette_t;

    // Draw item as latched at the input transfer
    typedef struct packed {
        logic [7:0] tile;
        logic       flip;
        logic       force0;
        logic       vis;
        logic [7:0] line_base;
        logic [7:0] col_base;
    } item_t;

    // One fetched pattern row, both planes
    typedef struct packed {
        logic       full;
        logic [7:0] plane0;
        logic [7:0] plane1;
    } row_buf_t;

endpackage

`default_nettype wire

@@ rtl/planar_tile_sprite_renderer.sv @@
// Load item: one transfer per cycle while no draw is in progress, written to pattern
// memory at the transfer. Draw item: the first pattern row (plane 0, then plane 1) is
// fetched into the row buffer, loaded into the shift registers and registered onto
// m_tdata; 64 pixels follow at one per cycle while m_tready is high; the next item is
// taken once the last pixel is in the output register. Reset (rst_n low, asynchronous):
// control state cleared, palette to defaults; pattern memory is not cleared.
`default_nettype none

module planar_tile_sprite_renderer #(
    parameter int PATTERN_BYTES = ptsr_pkg::PATTERN_BYTES_DEF,
    parameter int FRAME_LINES   = ptsr_pkg::FRAME_LINES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pattern_addr[11:0], pattern_byte[19:12], tile_index[27:20], tile_col[32:28],
    // tile_row[37:33], sprite_y[45:38], sprite_tile[53:46], sprite_attr[61:54],
    // sprite_x[69:62], zero[71:70]
    input  wire logic [ptsr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,  // cmd[1:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    output logic [ptsr_pkg::M_TDATA_W-1:0]         m_tdata,  // pixel_addr[15:0], pixel_color[39:16]
    output logic [0:0]                             m_tuser,  // write_enable[0]
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [ptsr_pkg::COLOR_W-1:0]      cfg_data
);

    localparam int ROW_LAST = FRAME_LINES / 8;

    logic [11:0]              pattern_addr;
    logic [7:0]               pattern_byte;
    logic [7:0]               tile_index;
    logic [4:0]               tile_col;
    logic [4:0]               tile_row;
    logic [7:0]               sprite_y;
    logic [7:0]               sprite_tile;
    logic [7:0]               sprite_attr;
    logic [7:0]               sprite_x;
    logic                     accept;
    logic                     load_wr;
    logic                     start;
    logic                     busy_reg;
    logic                     busy_next;
    ptsr_pkg::item_t          item_reg;
    ptsr_pkg::item_t          item_next;
    ptsr_pkg::palette_t       palette_reg;
    ptsr_pkg::palette_t       palette_next;
    ptsr_pkg::row_buf_t       row_buf;
    logic                     take;
    logic                     done;
    logic                     rd_en;
    logic [11:0]              rd_addr;
    logic [7:0]               rd_data;

    // Unpack the input fields
    assign pattern_addr = s_tdata[11:0];
    assign pattern_byte = s_tdata[19:12];
    assign tile_index   = s_tdata[27:20];
    assign tile_col     = s_tdata[32:28];
    assign tile_row     = s_tdata[37:33];
    assign sprite_y     = s_tdata[45:38];
    assign sprite_tile  = s_tdata[53:46];
    assign sprite_attr  = s_tdata[61:54];
    assign sprite_x     = s_tdata[69:62];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign load_wr  = accept && (s_tuser == ptsr_pkg::CMD_LOAD);
    assign start    = accept && ((s_tuser == ptsr_pkg::CMD_TILE)
                              || (s_tuser == ptsr_pkg::CMD_SPRITE));

    // Decode a draw item into its placement
    always_comb
    begin
        item_next = item_reg;
        case (s_tuser)
            ptsr_pkg::CMD_TILE:
            begin
                item_next.tile      = tile_index;
                item_next.flip      = 1'b0;
                item_next.force0    = 1'b0;
                item_next.vis       = (tile_row != 5'd0) && ({1'b0, tile_row} <= 6'(ROW_LAST));
                item_next.line_base = {5'(tile_row - 5'd1), 3'b000};
                item_next.col_base  = {tile_col, 3'b000};
            end
            ptsr_pkg::CMD_SPRITE:
            begin
                item_next.tile      = sprite_tile;
                item_next.flip      = sprite_attr[7];
                item_next.force0    = (sprite_attr[1:0] == ptsr_pkg::SPRITE_FORCE_ZERO);
                item_next.vis       = (sprite_y >= ptsr_pkg::SPRITE_Y_FIRST)
                                   && (sprite_y < ptsr_pkg::SPRITE_Y_END);
                item_next.line_base = sprite_y - ptsr_pkg::SPRITE_Y_FIRST;
                item_next.col_base  = sprite_x;
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    // Palette write decoder
    always_comb
    begin
        palette_next = palette_reg;
        if (cfg_wr_en)
        begin
            unique case (ptsr_pkg::reg_index_t'(cfg_index))
                ptsr_pkg::REG_COLOR_ZERO:  palette_next[0] = cfg_data;
                ptsr_pkg::REG_COLOR_ONE:   palette_next[1] = cfg_data;
                ptsr_pkg::REG_COLOR_TWO:   palette_next[2] = cfg_data;
                ptsr_pkg::REG_COLOR_THREE: palette_next[3] = cfg_data;
                default:                   palette_next = palette_reg;
            endcase
        end
    end

    // Hold the input closed from a draw transfer until its last pixel enters the output register
    always_comb
    begin
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            palette_reg[0] <= ptsr_pkg::COLOR_ZERO_RST;
            palette_reg[1] <= ptsr_pkg::COLOR_ONE_RST;
            palette_reg[2] <= ptsr_pkg::COLOR_TWO_RST;
            palette_reg[3] <= ptsr_pkg::COLOR_THREE_RST;
        end
        else
        begin
            busy_reg    <= busy_next;
            palette_reg <= palette_next;
        end
    end

    // Latched draw item
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= item_next;
        end
    end

    ptsr_pattern_mem #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_mem (
        .clk    (clk),
        .wr_en  (load_wr),
        .wr_addr(pattern_addr),
        .wr_data(pattern_byte),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    ptsr_row_fetch u_fetch (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .active (busy_reg),
        .item   (item_reg),
        .take   (take),
        .rd_data(rd_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .row_buf(row_buf)
    );

    ptsr_pixel_serial #(
        .FRAME_LINES(FRAME_LINES)
    ) u_serial (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item_reg),
        .palette (palette_reg),
        .row_buf (row_buf),
        .take    (take),
        .done    (done),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/ptsr_pattern_mem.sv @@
`default_nettype none

module ptsr_pattern_mem #(
    parameter int PATTERN_BYTES = ptsr_pkg::PATTERN_BYTES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [ptsr_pkg::PATTERN_ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                          wr_data,
    input  wire logic                                rd_en,
    input  wire logic [ptsr_pkg::PATTERN_ADDR_W-1:0] rd_addr,
    output logic      [7:0]                          rd_data
);

    localparam int AW = $clog2(PATTERN_BYTES);
    localparam int RW = 17;
    localparam logic [RW-1:0] DEPTH = RW'(PATTERN_BYTES);

    logic [7:0]    mem [PATTERN_BYTES];
    logic [7:0]    rd_data_reg;
    logic [RW-1:0] wr_red;
    logic [RW-1:0] rd_red;

    // Wrap both addresses into the memory depth by restoring subtraction
    always_comb
    begin
        wr_red = RW'(wr_addr);
        rd_red = RW'(rd_addr);
        for (int k = 3; k >= 0; k--)
        begin
            if (wr_red >= (DEPTH << k))
            begin
                wr_red = wr_red - (DEPTH << k);
            end
            if (rd_red >= (DEPTH << k))
            begin
                rd_red = rd_red - (DEPTH << k);
            end
        end
    end

    // Store load bytes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_red[AW-1:0]] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_red[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/ptsr_row_fetch.sv @@
`default_nettype none

module ptsr_row_fetch (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                active,
    input  wire ptsr_pkg::item_t                     item,
    input  wire logic                                take,
    input  wire logic [7:0]                          rd_data,
    output logic                                     rd_en,
    output logic      [ptsr_pkg::PATTERN_ADDR_W-1:0] rd_addr,
    output ptsr_pkg::row_buf_t                       row_buf
);

    typedef enum logic [2:0] {
        FS_WAIT    = 3'b001,
        FS_PLANE1  = 3'b010,
        FS_CAPTURE = 3'b100
    } fetch_state_t;

    fetch_state_t state_reg;
    fetch_state_t state_next;
    logic [3:0]   frow_reg;
    logic [3:0]   frow_next;
    logic         nfull_reg;
    logic         nfull_next;
    logic [7:0]   nb0_reg;
    logic [7:0]   nb0_next;
    logic [7:0]   nb1_reg;
    logic [7:0]   nb1_next;
    logic [2:0]   src_row;
    logic         plane_sel;
    logic         issue_ok;

    // Source row, flipped for mirrored sprites; address is tile*16 + plane*8 + row
    assign src_row   = item.flip ? ~frow_reg[2:0] : frow_reg[2:0];
    assign plane_sel = (state_reg == FS_PLANE1);
    assign rd_addr   = {item.tile, plane_sel, src_row};
    assign issue_ok  = active && !frow_reg[3] && !nfull_reg;
    assign rd_en     = ((state_reg == FS_WAIT) && issue_ok) || (state_reg == FS_PLANE1);

    // Fetch sequencer: issue plane 0, issue plane 1, capture both
    always_comb
    begin
        state_next = state_reg;
        frow_next  = frow_reg;
        nfull_next = nfull_reg;
        nb0_next   = nb0_reg;
        nb1_next   = nb1_reg;
        if (take)
        begin
            nfull_next = 1'b0;
        end
        unique case (state_reg)
            FS_WAIT:
            begin
                if (issue_ok)
                begin
                    state_next = FS_PLANE1;
                end
            end
            FS_PLANE1:
            begin
                nb0_next   = rd_data;
                state_next = FS_CAPTURE;
            end
            FS_CAPTURE:
            begin
                nb1_next   = rd_data;
                nfull_next = 1'b1;
                frow_next  = frow_reg + 4'd1;
                state_next = FS_WAIT;
            end
            default:
            begin
                state_next = FS_WAIT;
            end
        endcase
        if (start)
        begin
            frow_next  = 4'd0;
            nfull_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_WAIT;
            frow_reg  <= 4'(ptsr_pkg::TILE_ROWS);
            nfull_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frow_reg  <= frow_next;
            nfull_reg <= nfull_next;
        end
    end

    // Row buffer payload
    always_ff @(posedge clk)
    begin
        nb0_reg <= nb0_next;
        nb1_reg <= nb1_next;
    end

    assign row_buf.full   = nfull_reg;
    assign row_buf.plane0 = nb0_reg;
    assign row_buf.plane1 = nb1_reg;

endmodule

`default_nettype wire

@@ rtl/ptsr_pixel_serial.sv @@
`default_nettype none

module ptsr_pixel_serial #(
    parameter int FRAME_LINES = ptsr_pkg::FRAME_LINES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire ptsr_pkg::item_t                item,
    input  wire ptsr_pkg::palette_t             palette,
    input  wire ptsr_pkg::row_buf_t             row_buf,
    output logic                                take,
    output logic                                done,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ptsr_pkg::M_TDATA_W-1:0]      m_tdata,  // pixel_addr[15:0], pixel_color[39:16]
    output logic [0:0]                          m_tuser,  // write_enable[0]
    output logic                                m_tlast
);

    logic [7:0]                        sh0_reg;
    logic [7:0]                        sh0_next;
    logic [7:0]                        sh1_reg;
    logic [7:0]                        sh1_next;
    logic [3:0]                        bits_reg;
    logic [3:0]                        bits_next;
    logic [3:0]                        lrow_reg;
    logic [3:0]                        lrow_next;
    logic                              out_valid_reg;
    logic [ptsr_pkg::M_TDATA_W-1:0]    out_data_reg;
    logic                              out_we_reg;
    logic                              out_last_reg;
    logic                              pix_valid;
    logic                              load_out;
    logic [2:0]                        row_i;
    logic [2:0]                        col_c;
    logic [7:0]                        line;
    logic [8:0]                        colx;
    logic                              we;
    logic [1:0]                        idx;
    logic [ptsr_pkg::COLOR_W-1:0]      color;
    logic                              pix_last;

    // Move a pixel into the output register when it is empty or being drained
    assign pix_valid = (bits_reg != 4'd0);
    assign load_out  = pix_valid && (!out_valid_reg || m_tready);
    assign take      = row_buf.full && ((bits_reg == 4'd0) || (load_out && (bits_reg == 4'd1)));

    // Pixel position: row from rows loaded, column from bits left
    assign row_i = 3'(lrow_reg - 4'd1);
    assign col_c = 3'(bits_reg - 4'd1);
    assign line  = item.line_base + 8'(row_i);
    assign colx  = {1'b0, item.col_base} + 9'(col_c);
    assign we    = item.vis && (line < 8'(FRAME_LINES)) && !colx[8];

    // Palette index from the low bit of each plane, or zero for force-zero sprites
    assign idx      = item.force0 ? 2'd0 : {sh1_reg[0], sh0_reg[0]};
    assign color    = palette[idx];
    assign pix_last = (lrow_reg == 4'(ptsr_pkg::TILE_ROWS)) && (bits_reg == 4'd1);
    assign done     = load_out && pix_last;

    // Shift the planes out one bit per pixel, reload at each row boundary
    always_comb
    begin
        sh0_next  = sh0_reg;
        sh1_next  = sh1_reg;
        bits_next = bits_reg;
        lrow_next = lrow_reg;
        if (take)
        begin
            sh0_next  = row_buf.plane0;
            sh1_next  = row_buf.plane1;
            bits_next = 4'd8;
            lrow_next = lrow_reg + 4'd1;
        end
        else if (load_out)
        begin
            sh0_next  = {1'b0, sh0_reg[7:1]};
            sh1_next  = {1'b0, sh1_reg[7:1]};
            bits_next = bits_reg - 4'd1;
        end
        if (start)
        begin
            lrow_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= 4'd0;
            lrow_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            lrow_reg <= lrow_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Shift registers and output payload
    always_ff @(posedge clk)
    begin
        sh0_reg <= sh0_next;
        sh1_reg <= sh1_next;
        if (load_out)
        begin
            out_data_reg <= we ? {color, line, colx[7:0]} : '0;
            out_we_reg   <= we;
            out_last_reg <= pix_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_we_reg;
    assign m_tlast    = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/ptsr_checker.sv @@
`default_nettype none

`include "planar_tile_sprite_renderer_assert.svh"

module ptsr_checker #(
    parameter int FRAME_LINES = ptsr_pkg::FRAME_LINES_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic [1:0]                     s_tuser,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [ptsr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]                     m_tuser,
    input wire logic                           m_tlast,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    // A stalled pixel keeps its payload
    `PTSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // A pixel that is not stored carries zero address and color
    `PTSR_ASSERT_IMPLY(a_skip_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

    // A stored pixel lies on a visible line
    `PTSR_ASSERT_IMPLY(a_line_range, m_tvalid && m_tuser[0], m_tdata[15:8] < 8'(FRAME_LINES))

    // A draw transfer closes the input for the following cycle
    `PTSR_ASSERT_NEXT(a_draw_busy,
        s_tvalid && s_tready && (s_tuser == ptsr_pkg::CMD_TILE || s_tuser == ptsr_pkg::CMD_SPRITE),
        !s_tready)

endmodule

bind planar_tile_sprite_renderer ptsr_checker #(.FRAME_LINES(FRAME_LINES)) u_ptsr_checker (.*);

`default_nettype wire
